[hw/rtl/utt_pkg.sv]
// Shared types, constants and the code point encoder of the UTF-16/UTF-32 transcoder.
`timescale 1ns / 1ps

package utt_pkg;

   // Format register bits: bit 0 big endian, bit 1 UTF-32
   localparam int FMT_BIG_ENDIAN_BIT = 0;
   localparam int FMT_UTF32_BIT      = 1;

   // Register indexes on the csr port
   localparam logic REG_SOURCE_FORMAT = 1'b0;
   localparam logic REG_TARGET_FORMAT = 1'b1;

   // Error codes
   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_RANGE  = 2'd1;
   localparam logic [1:0] ERR_LENGTH = 2'd2;

   localparam logic [31:0] CP_MAX           = 32'h0010_FFFF;
   localparam logic [31:0] SUPP_BASE        = 32'h0001_0000;
   localparam logic [15:0] HIGH_SURR_BASE   = 16'hD800;
   localparam logic [15:0] LOW_SURR_BASE    = 16'hDC00;
   localparam logic [5:0]  HIGH_SURR_PREFIX = 6'b110110;
   localparam logic [5:0]  LOW_SURR_PREFIX  = 6'b110111;

   typedef struct packed {
      logic [31:0] unit_assembly;
      logic [1:0]  bytes_gathered;
      logic [9:0]  pend_high;
      logic        pend_valid;
      logic        drop;
   } utt_state_type;

   // All results caused by one request, byte 0 goes out first
   typedef struct packed {
      logic [7:0][7:0] data;
      logic [3:0]      count;
      logic            status;
      logic [1:0]      error;
      logic            last;
   } utt_burst_type;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic            four;
   } utt_enc_type;

   // Encode one code point (at most 0x10FFFF) in the given target format
   function automatic utt_enc_type encode_cp(input logic [20:0] cp, input logic [1:0] fmt);
      utt_enc_type e;
      logic [19:0] c;
      logic [15:0] hi;
      logic [15:0] lo;
      logic [15:0] u0;
      logic [31:0] word;
      c    = 20'(cp - SUPP_BASE[20:0]);
      hi   = HIGH_SURR_BASE | {6'd0, c[19:10]};
      lo   = LOW_SURR_BASE | {6'd0, c[9:0]};
      u0   = cp[15:0];
      word = {11'd0, cp};
      if (fmt[FMT_UTF32_BIT]) begin
         e.four = 1'b1;
         if (fmt[FMT_BIG_ENDIAN_BIT]) begin
            e.bytes = {word[7:0], word[15:8], word[23:16], word[31:24]};
         end else begin
            e.bytes = word;
         end
      end else if (cp[20:16] != 5'd0) begin
         e.four = 1'b1;
         if (fmt[FMT_BIG_ENDIAN_BIT]) begin
            e.bytes = {lo[7:0], lo[15:8], hi[7:0], hi[15:8]};
         end else begin
            e.bytes = {lo, hi};
         end
      end else begin
         e.four = 1'b0;
         if (fmt[FMT_BIG_ENDIAN_BIT]) begin
            e.bytes = {16'd0, u0[7:0], u0[15:8]};
         end else begin
            e.bytes = {16'd0, u0};
         end
      end
      return e;
   endfunction

endpackage

[hw/rtl/utt_step.sv]
// Per-byte conversion step: unit assembly, surrogate handling and output burst build.
`timescale 1ns / 1ps

module utt_step (
   input  logic [1:0]             source_format,
   input  logic [1:0]             target_format,
   input  utt_pkg::utt_state_type state_cur,
   input  logic [7:0]             in_byte,
   input  logic                   in_last,
   output utt_pkg::utt_state_type state_nxt,
   output utt_pkg::utt_burst_type burst,
   output logic                   burst_valid
);

   logic [2:0]  cnt1;
   logic [31:0] shifted;
   logic [31:0] asm_new;
   logic        complete;
   logic [31:0] v;
   logic        to32;
   logic        is_bmp;
   logic        is_low;
   logic        is_high;
   logic        over;
   logic        supp;
   logic [20:0] pair_cp;
   logic [20:0] old_flush_cp;

   logic        flush_old;
   logic        main_v;
   logic [20:0] main_cp;
   logic        pend_after;
   logic [9:0]  pend_high_after;
   logic [1:0]  bg_after;
   logic        end_flush;
   logic [20:0] end_cp;
   logic [1:0]  err;
   logic        s0v;
   logic        s1v;
   logic [20:0] s0_cp;
   logic [20:0] s1_cp;
   utt_pkg::utt_enc_type e0;
   utt_pkg::utt_enc_type e1;
   logic [3:0]  len0;
   logic [3:0]  len1;

   assign cnt1     = {1'b0, state_cur.bytes_gathered} + 3'd1;
   assign shifted  = {24'd0, in_byte} << {state_cur.bytes_gathered, 3'b000};
   assign asm_new  = source_format[utt_pkg::FMT_BIG_ENDIAN_BIT] ?
                     {state_cur.unit_assembly[23:0], in_byte} :
                     (state_cur.unit_assembly | shifted);
   assign complete = source_format[utt_pkg::FMT_UTF32_BIT] ? (cnt1 >= 3'd4) : (cnt1 >= 3'd2);
   assign v        = source_format[utt_pkg::FMT_UTF32_BIT] ? asm_new : {16'd0, asm_new[15:0]};
   assign to32     = target_format[utt_pkg::FMT_UTF32_BIT];
   assign over     = v > utt_pkg::CP_MAX;
   assign supp     = !over && (v >= utt_pkg::SUPP_BASE);
   assign is_bmp   = (v[31:16] == 16'd0);
   assign is_low   = is_bmp && (v[15:10] == utt_pkg::LOW_SURR_PREFIX);
   assign is_high  = is_bmp && (v[15:10] == utt_pkg::HIGH_SURR_PREFIX);
   assign pair_cp  = utt_pkg::SUPP_BASE[20:0] + {1'b0, state_cur.pend_high, v[9:0]};
   assign old_flush_cp = {5'd0, utt_pkg::HIGH_SURR_PREFIX, state_cur.pend_high};

   always_comb begin
      flush_old       = 1'b0;
      main_v          = 1'b0;
      main_cp         = v[20:0];
      err             = utt_pkg::ERR_NONE;
      pend_after      = state_cur.pend_valid;
      pend_high_after = state_cur.pend_high;
      if (complete) begin
         if (over) begin
            err = utt_pkg::ERR_RANGE;
         end else if (supp) begin
            flush_old  = state_cur.pend_valid;
            main_v     = 1'b1;
            pend_after = 1'b0;
            pend_high_after = 10'd0;
         end else if (state_cur.pend_valid && to32 && is_low) begin
            main_v     = 1'b1;
            main_cp    = pair_cp;
            pend_after = 1'b0;
            pend_high_after = 10'd0;
         end else begin
            flush_old = state_cur.pend_valid;
            if (to32 && is_high) begin
               pend_after      = 1'b1;
               pend_high_after = v[9:0];
            end else begin
               main_v          = 1'b1;
               pend_after      = 1'b0;
               pend_high_after = 10'd0;
            end
         end
      end
      bg_after  = complete ? 2'd0 : cnt1[1:0];
      end_flush = 1'b0;
      if (err == utt_pkg::ERR_NONE && in_last) begin
         if (bg_after != 2'd0) begin
            err = utt_pkg::ERR_LENGTH;
         end else begin
            end_flush = pend_after;
         end
      end
   end

   assign end_cp = {5'd0, utt_pkg::HIGH_SURR_PREFIX, pend_high_after};

   // At most two code points go out per byte; pack them in order
   always_comb begin
      s0v   = flush_old || main_v || end_flush;
      s0_cp = flush_old ? old_flush_cp : (main_v ? main_cp : end_cp);
      if (flush_old) begin
         s1v   = main_v || end_flush;
         s1_cp = main_v ? main_cp : end_cp;
      end else begin
         s1v   = main_v && end_flush;
         s1_cp = end_cp;
      end
   end

   assign e0   = utt_pkg::encode_cp(s0_cp, target_format);
   assign e1   = utt_pkg::encode_cp(s1_cp, target_format);
   assign len0 = !s0v ? 4'd0 : (e0.four ? 4'd4 : 4'd2);
   assign len1 = !s1v ? 4'd0 : (e1.four ? 4'd4 : 4'd2);

   always_comb begin
      state_nxt   = state_cur;
      burst       = '0;
      burst.last  = in_last;
      burst_valid = 1'b0;
      if (state_cur.drop) begin
         if (in_last) begin
            state_nxt    = '0;
            burst.status = 1'b1;
            burst.count  = 4'd1;
            burst.error  = utt_pkg::ERR_NONE;
            burst_valid  = 1'b1;
         end
      end else if (err != utt_pkg::ERR_NONE) begin
         state_nxt      = '0;
         state_nxt.drop = !in_last;
         burst.status   = 1'b1;
         burst.count    = 4'd1;
         burst.error    = err;
         burst_valid    = 1'b1;
      end else begin
         if (in_last) begin
            state_nxt = '0;
         end else begin
            state_nxt.unit_assembly  = complete ? 32'd0 : asm_new;
            state_nxt.bytes_gathered = bg_after;
            state_nxt.pend_valid     = pend_after;
            state_nxt.pend_high      = pend_high_after;
            state_nxt.drop           = 1'b0;
         end
         if (e0.four) begin
            burst.data = {e1.bytes, e0.bytes};
         end else begin
            burst.data = {16'd0, e1.bytes, e0.bytes[1:0]};
         end
         burst.count = len0 + len1;
         burst_valid = s0v;
      end
   end

endmodule

[hw/rtl/utf16_utf32_transcoder_top.sv]
// Top level of the UTF-16/UTF-32 byte-stream transcoder: registers, handshakes, output serializer.
`timescale 1ns / 1ps

// Takes encoded text one byte per request and returns the converted text one
// byte per response. Each request is converted in the cycle it is accepted and
// its results (up to eight bytes, or one status item) are loaded into a burst
// register; the serializer then hands them out one per cycle while rsp_ready is
// high. A request that only adds to a partial code unit produces nothing and
// leaves the burst register empty. A request that completes a unit occupies the
// burst register until all of its bytes (2, 4 or up to 8 when a held surrogate
// is flushed too) have left; the next request is accepted in the cycle the last
// byte of the burst leaves. Errors come back as a status item (rsp_byte_valid
// low) carrying rsp_error_code; after an error the rest of the message is
// dropped and its last byte returns a single status item with rsp_message_end
// set.
// Write source_format (index 0) and target_format (index 1) only while idle.
module utf16_utf32_transcoder_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic [1:0] csr_write_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_run_last,
   output logic       rsp_message_end,
   output logic [1:0] rsp_error_code
);

   logic [1:0]             source_format_ff;
   logic [1:0]             target_format_ff;
   utt_pkg::utt_state_type state_ff;
   utt_pkg::utt_state_type state_in;
   utt_pkg::utt_burst_type burst_ff;
   utt_pkg::utt_burst_type burst_in;
   logic                   burst_new;
   logic                   hold_valid_ff;
   logic [2:0]             idx_ff;
   logic                   req_accept;
   logic                   rsp_accept;
   logic                   finishing;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         source_format_ff <= 2'd0;
         target_format_ff <= 2'd0;
      end else if (csr_write_enable) begin
         if (csr_index == utt_pkg::REG_SOURCE_FORMAT) begin
            source_format_ff <= csr_write_data;
         end
         if (csr_index == utt_pkg::REG_TARGET_FORMAT) begin
            target_format_ff <= csr_write_data;
         end
      end
   end

   utt_step u_step (
      .source_format (source_format_ff),
      .target_format (target_format_ff),
      .state_cur     (state_ff),
      .in_byte       (req_in_byte),
      .in_last       (req_in_last),
      .state_nxt     (state_in),
      .burst         (burst_in),
      .burst_valid   (burst_new)
   );

   // Response side: walk the held burst one byte per accepted response
   assign rsp_valid       = hold_valid_ff;
   assign rsp_out_byte    = burst_ff.data[idx_ff];
   assign rsp_byte_valid  = !burst_ff.status;
   assign rsp_run_last    = ({1'b0, idx_ff} + 4'd1) == burst_ff.count;
   assign rsp_message_end = rsp_run_last && burst_ff.last;
   assign rsp_error_code  = burst_ff.error;

   assign rsp_accept = rsp_valid && rsp_ready;
   assign finishing  = rsp_accept && rsp_run_last;

   // Take a new request while the burst register is empty or frees this cycle
   assign req_ready  = !hold_valid_ff || finishing;
   assign req_accept = req_valid && req_ready;

   // Conversion state advances once per accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   // Burst payload: load on a request that yields results
   always_ff @(posedge clock) begin
      if (req_accept && burst_new) begin
         burst_ff <= burst_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         idx_ff        <= 3'd0;
      end else if (req_accept && burst_new) begin
         hold_valid_ff <= 1'b1;
         idx_ff        <= 3'd0;
      end else if (finishing) begin
         hold_valid_ff <= 1'b0;
         idx_ff        <= 3'd0;
      end else if (rsp_accept) begin
         idx_ff <= idx_ff + 3'd1;
      end
   end

`ifndef NO_ASSERTIONS
   // A status item stands alone in its run
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_run_last)
      else $error("status item not last of its run");

   // Error codes ride only on status items
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != utt_pkg::ERR_NONE |-> !rsp_byte_valid)
      else $error("error code on a data byte");

   // While dropping, no surrogate is held and no unit is half built
   assert property (@(posedge clock) disable iff (reset)
      state_ff.drop |-> !state_ff.pend_valid && state_ff.bytes_gathered == 2'd0)
      else $error("message state left over while dropping");

   // A stalled burst keeps its position
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(idx_ff))
      else $error("burst position moved while stalled");
`endif

endmodule

[verif/tb_top.sv]
// Self-checking testbench of the UTF-16/UTF-32 transcoder: directed and random text.
`timescale 1ns / 1ps

module tb_top;

   // Byte-stream formats as written to source_format and target_format
   localparam logic [1:0] FMT_U16LE = 2'd0;
   localparam logic [1:0] FMT_U16BE = 2'd1;
   localparam logic [1:0] FMT_U32LE = 2'd2;
   localparam logic [1:0] FMT_U32BE = 2'd3;

   // One response item as it leaves the block
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       run_last;
      logic       message_end;
      logic [1:0] error_code;
   } conv_item_type;

   // A code point written out in some format; b[0] goes first
   typedef struct packed {
      logic [3:0][7:0] b;
      logic [2:0]      n;
   } cp_bytes_type;

   logic       clock;
   logic       reset;
   logic       csr_write_enable;
   logic       csr_index;
   logic [1:0] csr_write_data;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_in_byte;
   logic       req_in_last;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_run_last;
   logic       rsp_message_end;
   logic [1:0] rsp_error_code;

   utf16_utf32_transcoder_top u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .req_in_last     (req_in_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_run_last    (rsp_run_last),
      .rsp_message_end (rsp_message_end),
      .rsp_error_code  (rsp_error_code)
   );

   // Transcoder mirror: formats and the per-message assembly state
   logic [1:0]  src_fmt;
   logic [1:0]  tgt_fmt;
   logic [31:0] acc_word;
   logic [1:0]  acc_count;
   logic [9:0]  held_hi;
   logic        held_on;
   logic        skip_to_end;

   // Bytes produced by the request being mirrored
   logic [7:0]  out_buf [8];
   int          out_cnt;

   // Converted text still owed by the block, oldest first
   conv_item_type converted_q [$];

   int mismatch_count = 0;
   int requests_sent  = 0;

   // Sender pacing: burst length left, and a switch for gap-free stretches
   int burst_left = 0;
   bit steady     = 1'b0;

   // Long receiver hold-off, picked up by the response pacer
   int hold_request = 0;

   // ------------------------------------------------------------------
   // Clock and the overall time limit
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   // ------------------------------------------------------------------
   // Encoding of one code point, shared by stimulus and mirror
   // ------------------------------------------------------------------
   function automatic cp_bytes_type cp_to_bytes(input logic [31:0] cp, input logic [1:0] fmt);
      cp_bytes_type e;
      logic [19:0]  c;
      logic [15:0]  u0;
      logic [15:0]  u1;
      bit           be;
      be = fmt[utt_pkg::FMT_BIG_ENDIAN_BIT];
      e  = '0;
      if (fmt[utt_pkg::FMT_UTF32_BIT]) begin
         e.n = 3'd4;
         if (be) begin
            e.b = {cp[7:0], cp[15:8], cp[23:16], cp[31:24]};
         end else begin
            e.b = cp;
         end
      end else begin
         // Supplementary planes split into a high and a low surrogate
         if (cp >= 32'h0001_0000) begin
            c   = 20'(cp - 32'h0001_0000);
            u0  = 16'hD800 | {6'd0, c[19:10]};
            u1  = 16'hDC00 | {6'd0, c[9:0]};
            e.n = 3'd4;
         end else begin
            u0  = cp[15:0];
            u1  = 16'd0;
            e.n = 3'd2;
         end
         if (be) begin
            e.b = {u1[7:0], u1[15:8], u0[7:0], u0[15:8]};
         end else begin
            e.b = {u1, u0};
         end
      end
      return e;
   endfunction

   task automatic push_cp(input logic [31:0] cp);
      cp_bytes_type e;
      e = cp_to_bytes(cp, tgt_fmt);
      for (int i = 0; i < e.n; i++) begin
         if (out_cnt < 8) begin
            out_buf[out_cnt] = e.b[i];
            out_cnt++;
         end
      end
   endtask

   // Emit a held high surrogate as a code point of its own
   task automatic flush_held();
      if (held_on) begin
         push_cp(32'h0000_D800 | {22'd0, held_hi});
         held_on = 1'b0;
         held_hi = '0;
      end
   endtask

   // A BMP unit: join with a held high surrogate, hold a new one, or pass on
   task automatic take_bmp(input logic [15:0] u);
      bit to32;
      to32 = tgt_fmt[utt_pkg::FMT_UTF32_BIT];
      if (held_on && to32 && u[15:10] == utt_pkg::LOW_SURR_PREFIX) begin
         push_cp(32'h0001_0000 + {12'd0, held_hi, 10'd0} + {22'd0, u[9:0]});
         held_on = 1'b0;
         held_hi = '0;
      end else begin
         flush_held();
         if (to32 && u[15:10] == utt_pkg::HIGH_SURR_PREFIX) begin
            held_hi = u[9:0];
            held_on = 1'b1;
         end else begin
            push_cp({16'd0, u});
         end
      end
   endtask

   task automatic clear_text();
      acc_word  = '0;
      acc_count = '0;
      held_hi   = '0;
      held_on   = 1'b0;
   endtask

   task automatic reset_transcode();
      src_fmt     = FMT_U16LE;
      tgt_fmt     = FMT_U16LE;
      skip_to_end = 1'b0;
      clear_text();
   endtask

   // Mirror one accepted request and queue the response items it owes
   task automatic transcode_byte(input logic [7:0] b, input logic is_last);
      logic [2:0]    cnt;
      logic [2:0]    unit_size;
      logic [31:0]   v;
      logic [1:0]    err;
      bit            status;
      int            n;
      conv_item_type item;
      out_cnt = 0;
      err     = utt_pkg::ERR_NONE;
      status  = 1'b0;
      if (skip_to_end) begin
         // Dropping after an error: only the closing byte answers
         if (is_last) begin
            skip_to_end = 1'b0;
            clear_text();
            status = 1'b1;
         end
      end else begin
         unit_size = src_fmt[utt_pkg::FMT_UTF32_BIT] ? 3'd4 : 3'd2;
         cnt       = {1'b0, acc_count};
         if (src_fmt[utt_pkg::FMT_BIG_ENDIAN_BIT]) begin
            acc_word = {acc_word[23:0], b};
         end else begin
            acc_word = acc_word | (32'(b) << (8 * cnt));
         end
         cnt++;
         // The count may already exceed the unit size after a format switch
         if (cnt >= unit_size) begin
            v         = src_fmt[utt_pkg::FMT_UTF32_BIT] ? acc_word : {16'd0, acc_word[15:0]};
            acc_word  = '0;
            acc_count = '0;
            if (v > 32'h0010_FFFF) begin
               err = utt_pkg::ERR_RANGE;
            end else if (v >= 32'h0001_0000) begin
               flush_held();
               push_cp(v);
            end else begin
               take_bmp(v[15:0]);
            end
         end else begin
            acc_count = cnt[1:0];
         end
         if (err == utt_pkg::ERR_NONE && is_last) begin
            if (acc_count != 2'd0) begin
               err = utt_pkg::ERR_LENGTH;
            end else begin
               flush_held();
            end
         end
         if (err != utt_pkg::ERR_NONE) begin
            out_cnt = 0;
            clear_text();
            status = 1'b1;
            if (!is_last) begin
               skip_to_end = 1'b1;
            end
         end
         if (is_last) begin
            clear_text();
         end
      end
      n = status ? 1 : out_cnt;
      for (int k = 0; k < n; k++) begin
         item.out_byte    = status ? 8'd0 : out_buf[k];
         item.byte_valid  = !status;
         item.run_last    = (k == n - 1);
         item.message_end = is_last && (k == n - 1);
         item.error_code  = status ? err : utt_pkg::ERR_NONE;
         converted_q.push_back(item);
      end
   endtask

   // ------------------------------------------------------------------
   // Response checker: compare every accepted response with the oldest
   // expectation, field by field
   // ------------------------------------------------------------------
   always @(posedge clock) begin : rsp_check
      conv_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (converted_q.size() == 0) begin
            if (mismatch_count < 10) begin
               $display("%0t unexpected response byte=%h valid=%b run=%b end=%b err=%0d",
                        $time, rsp_out_byte, rsp_byte_valid, rsp_run_last,
                        rsp_message_end, rsp_error_code);
            end
            mismatch_count++;
         end else begin
            want = converted_q.pop_front();
            if (rsp_out_byte !== want.out_byte || rsp_byte_valid !== want.byte_valid ||
                rsp_run_last !== want.run_last || rsp_message_end !== want.message_end ||
                rsp_error_code !== want.error_code) begin
               if (mismatch_count < 10) begin
                  $display("%0t mismatch byte %h/%h valid %b/%b run %b/%b end %b/%b err %0d/%0d",
                           $time, want.out_byte, rsp_out_byte, want.byte_valid,
                           rsp_byte_valid, want.run_last, rsp_run_last, want.message_end,
                           rsp_message_end, want.error_code, rsp_error_code);
               end
               mismatch_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Response pacer: stall on a changing duty pattern, with occasional
   // fully open stretches, and honor a long hold-off when asked
   // ------------------------------------------------------------------
   initial begin : rsp_pacer
      int hold_left;
      int pattern_left;
      int stall_pct;
      rsp_ready    = 1'b0;
      hold_left    = 0;
      pattern_left = 0;
      stall_pct    = 0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (pattern_left == 0) begin
            pattern_left = $urandom_range(40, 160);
            case ($urandom_range(0, 3))
               0: stall_pct = 0;
               1: stall_pct = 25;
               2: stall_pct = 50;
               default: stall_pct = 85;
            endcase
         end
         pattern_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   // Drop valid between bursts
   task automatic idle_sender(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Offer one request, hold it until accepted, then mirror it
   task automatic send_byte(input logic [7:0] b, input logic is_last);
      @(negedge clock);
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_in_last <= is_last;
      do @(posedge clock); while (req_ready !== 1'b1);
      requests_sent++;
      transcode_byte(b, is_last);
      // Advance the burst pattern unless running gap-free
      if (!steady) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            idle_sender($urandom_range(1, 6));
            burst_left = $urandom_range(0, 10);
         end
      end
   endtask

   // Stop sending, wait for every owed response, then let the block settle
   task automatic drain_text();
      int waited;
      waited = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (converted_q.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      if (idx == utt_pkg::REG_SOURCE_FORMAT) begin
         src_fmt = value;
      end else begin
         tgt_fmt = value;
      end
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Formats change only once the block has gone quiet
   task automatic set_formats(input logic [1:0] src, input logic [1:0] tgt);
      drain_text();
      write_csr(utt_pkg::REG_SOURCE_FORMAT, src);
      write_csr(utt_pkg::REG_TARGET_FORMAT, tgt);
   endtask

   // Random code point suited to the current source format
   function automatic logic [31:0] pick_cp();
      int          r;
      logic [31:0] v;
      r = $urandom_range(0, 99);
      if (r < 30) begin
         v = $urandom_range(0, 32'h7F);
      end else if (r < 50) begin
         v = $urandom_range(0, 32'hFFFF);
      end else if (r < 70) begin
         v = $urandom_range(32'h0001_0000, 32'h0010_FFFF);
      end else if (r < 80) begin
         v = $urandom_range(32'hD800, 32'hDBFF);
      end else if (r < 88) begin
         v = $urandom_range(32'hDC00, 32'hDFFF);
      end else if (r < 97 || !src_fmt[utt_pkg::FMT_UTF32_BIT]) begin
         case ($urandom_range(0, 3))
            0: v = 32'h0000_0000;
            1: v = 32'h0000_FFFF;
            2: v = 32'h0001_0000;
            default: v = 32'h0010_FFFF;
         endcase
      end else begin
         // Out of range, only reachable from a UTF-32 source
         v = $urandom;
         if (v <= 32'h0010_FFFF) begin
            v = v | 32'h8000_0000;
         end
      end
      return v;
   endfunction

   // One message: mostly well-formed text, some cut short, some noise
   task automatic send_text();
      logic [7:0]   text [$];
      logic [31:0]  cp;
      cp_bytes_type e;
      int           kind;
      int           cut;
      text = {};
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         repeat ($urandom_range(1, 7)) text.push_back(8'($urandom));
      end else begin
         repeat ($urandom_range(1, 6)) begin
            cp = pick_cp();
            e  = cp_to_bytes(cp, src_fmt);
            for (int i = 0; i < e.n; i++) text.push_back(e.b[i]);
            // Pair a high surrogate with a low one half the time
            if (cp[31:10] == 22'h36 && $urandom_range(0, 1) == 1) begin
               e = cp_to_bytes(32'hDC00 | 32'($urandom_range(0, 32'h3FF)), src_fmt);
               for (int i = 0; i < e.n; i++) text.push_back(e.b[i]);
            end
         end
         if (kind < 18 && text.size() > 1) begin
            cut = $urandom_range(1, src_fmt[utt_pkg::FMT_UTF32_BIT] ? 3 : 1);
            if (cut >= text.size()) begin
               cut = text.size() - 1;
            end
            repeat (cut) void'(text.pop_back());
         end
      end
      foreach (text[i]) begin
         send_byte(text[i], i == text.size() - 1);
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // UTF-16 BE into UTF-32 LE: join a pair, flush a held high surrogate
   // before a plain unit, and flush one held at the end of the message
   task automatic test_surrogate_joining();
      set_formats(FMT_U16BE, FMT_U32LE);
      send_byte(8'hD8, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hDC, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hDB, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hD8, 1'b0);
      send_byte(8'h00, 1'b1);
   endtask

   // UTF-32 into UTF-16: top code point as a pair, out-of-range value
   // mid-message with the rest dropped, and one on the closing byte
   task automatic test_range_and_drop();
      set_formats(FMT_U32BE, FMT_U16BE);
      send_byte(8'h00, 1'b0);
      send_byte(8'h10, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h11, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      set_formats(FMT_U32LE, FMT_U16LE);
      repeat (3) send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
   endtask

   // A message that stops inside a code unit
   task automatic test_short_message();
      set_formats(FMT_U16LE, FMT_U16LE);
      send_byte(8'h41, 1'b1);
   endtask

   // Widen the source format after the first byte of a unit
   task automatic test_format_switch_mid_unit();
      set_formats(FMT_U16LE, FMT_U16LE);
      send_byte(8'h41, 1'b0);
      drain_text();
      write_csr(utt_pkg::REG_SOURCE_FORMAT, FMT_U32LE);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);
   endtask

   // Random text across format pairs; the corner pairs come first
   task automatic test_random_text();
      int phase;
      phase = 0;
      while (requests_sent < 350) begin
         case (phase)
            0: set_formats(FMT_U16LE, FMT_U16LE);
            1: set_formats(FMT_U32BE, FMT_U32BE);
            2: set_formats(FMT_U16LE, FMT_U32BE);
            3: set_formats(FMT_U32BE, FMT_U16LE);
            default: set_formats(2'($urandom), 2'($urandom));
         endcase
         steady = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(3, 6)) send_text();
         phase++;
      end
      steady = 1'b0;
   endtask

   // Hold off the receiver while UTF-16 doubles into UTF-32, so the
   // block fills up and stalls its request side
   task automatic test_output_backpressure();
      set_formats(FMT_U16LE, FMT_U32BE);
      steady = 1'b1;
      send_byte(8'h41, 1'b0);
      hold_request = 150;
      repeat (14) begin
         send_byte(8'($urandom), 1'b0);
      end
      send_byte(8'h42, 1'b0);
      send_byte(8'h00, 1'b1);
      steady = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = utt_pkg::REG_SOURCE_FORMAT;
      csr_write_data   = FMT_U16LE;
      req_valid        = 1'b0;
      req_in_byte      = 8'd0;
      req_in_last      = 1'b0;
      reset_transcode();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_surrogate_joining();
      test_range_and_drop();
      test_short_message();
      test_format_switch_mid_unit();
      test_random_text();
      test_output_backpressure();

      // Wait for the tail, then count anything still owed as a failure
      drain_text();
      repeat (10) @(posedge clock);
      if (converted_q.size() != 0) begin
         $display("%0d expected responses never arrived", converted_q.size());
         mismatch_count += converted_q.size();
      end
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
